/* design/fss_pkg.sv */
// ----------------------------------------------------------------------------
// Fibonacci search package
// Shared widths and request codes for the sorted-table Fibonacci search.
// ----------------------------------------------------------------------------
package fss_pkg;

  // Width of the table length register.
  localparam int unsigned LenW = 11;
  // Fibonacci terms; the largest term reached for an 11-bit length is 2584.
  localparam int unsigned FibW = 12;
  // Offset is signed and starts at minus one.
  localparam int unsigned OffW = 12;
  // Signed sum of offset and the small Fibonacci term.
  localparam int unsigned SumW = 14;
  localparam int unsigned IdxW = 10;
  localparam int unsigned PosW = 10;
  localparam int unsigned CntW = 5;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

endpackage

/* design/fss_req_if.sv */
// ----------------------------------------------------------------------------
// Fibonacci search request channel
// Valid/ready channel carrying one write or search word.
// ----------------------------------------------------------------------------
interface fss_req_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  import fss_pkg::*;

  logic                   valid;
  logic                   ready;
  req_type_e              req_type;
  logic [IdxW-1:0]        entry_index;
  logic [VALUE_WIDTH-1:0] item_value;

  modport source (output valid, output req_type, output entry_index, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input entry_index, input item_value,
                  output ready);
endinterface

/* design/fss_rsp_if.sv */
// ----------------------------------------------------------------------------
// Fibonacci search result channel
// Valid/ready channel carrying one search result word.
// ----------------------------------------------------------------------------
interface fss_rsp_if;
  import fss_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] position;
  logic [CntW-1:0] probe_count;

  modport source (output valid, output found, output position, output probe_count,
                  input ready);
  modport sink   (input valid, input found, input position, input probe_count,
                  output ready);
endinterface

/* design/fss_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fibonacci_search_sorted_table.sv */
// ----------------------------------------------------------------------------
// Fibonacci search over a sorted table
// Stores signed values in a RAM and answers search words with found,
// position and probe count using a Fibonacci-window probe sequence.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Word
//  req_i    in   valid/ready   req_type, entry_index, item_value
//  rsp_o    out  valid/ready   found, position, probe_count (searches only)
//  cfg      in   cfg_we_i      cfg_wdata_i = table_length
//
// A write word goes straight into the RAM when it is accepted.
// A search runs through growth steps that widen the Fibonacci window, a step
// that issues the first read, one probe per read, a neighbor check when the
// probes end without a hit and one is left to check, and a step that loads the
// output register; the next word is taken once the block is back in idle.
// Reset clears control only; table contents are undefined until written.
// A finished result waits in the output register; a new word is accepted
// meanwhile, and a search that finishes while that register is full waits.

module fibonacci_search_sorted_table #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  fss_req_if.sink                  req_i,
  fss_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [fss_pkg::LenW-1:0] cfg_wdata_i
);
  import fss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GROW  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [LenW-1:0]               len_q;
  logic [LenW-1:0]               n;
  logic signed [VALUE_WIDTH-1:0] target_q, target_d;
  logic [FibW-1:0]               f2_q, f2_d, f1_q, f1_d, fm_q, fm_d;
  logic signed [OffW-1:0]        off_q, off_d;
  logic [LenW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]               probes_q, probes_d;
  logic                          res_found_q, res_found_d;
  logic [PosW-1:0]               res_pos_q, res_pos_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_found_q, out_found_d;
  logic [PosW-1:0]               out_pos_q, out_pos_d;
  logic [CntW-1:0]               out_cnt_q, out_cnt_d;

  // Candidate window after this cycle's step, used to pick the next read.
  logic [FibW-1:0]               c_f2, c_f1, c_fm;
  logic signed [OffW-1:0]        c_off;
  logic                          do_exit;

  logic signed [SumW-1:0]        probe_sum;
  logic [LenW-1:0]               probe_idx;
  logic [OffW-1:0]               last_idx;

  logic                          req_fire, ram_we, ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] rd_val;

  // Table length saturates at the table depth.
  assign n = (32'(len_q) > 32'(DEPTH)) ? LenW'(DEPTH) : len_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign ram_we      = req_fire && (req_i.req_type == REQ_WRITE) &&
                       (32'(req_i.entry_index) < 32'(DEPTH));

  fss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.entry_index)),
    .wdata_i (req_i.item_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val = $signed(ram_rdata);

  // Probe index: offset plus the small term, clamped into [0, n-1].
  assign probe_sum = SumW'(c_off) + $signed({2'b00, c_f2});
  always_comb begin
    if (probe_sum < 0) begin
      probe_idx = '0;
    end else if (probe_sum >= $signed({3'b000, n})) begin
      probe_idx = n - LenW'(1);
    end else begin
      probe_idx = probe_sum[LenW-1:0];
    end
  end
  assign last_idx = OffW'(c_off) + OffW'(1);

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    f2_d        = f2_q;
    f1_d        = f1_q;
    fm_d        = fm_q;
    off_d       = off_q;
    idx_d       = idx_q;
    probes_d    = probes_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    c_f2        = f2_q;
    c_f1        = f1_q;
    c_fm        = fm_q;
    c_off       = off_q;
    do_exit     = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(probe_idx);

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire && (req_i.req_type == REQ_SEARCH)) begin
          target_d = $signed(req_i.item_value);
          f2_d     = '0;
          f1_d     = FibW'(1);
          fm_d     = FibW'(1);
          off_d    = -OffW'(1);
          probes_d = '0;
          state_d  = ST_GROW;
        end
      end
      ST_GROW: begin
        if (fm_q < FibW'(n)) begin
          f2_d = f1_q;
          f1_d = fm_q;
          fm_d = f1_q + fm_q;
        end else begin
          do_exit = 1'b1;
        end
      end
      ST_PROBE: begin
        probes_d = probes_q + CntW'(1);
        if (rd_val < target_q) begin
          c_fm    = f1_q;
          c_f1    = f2_q;
          c_f2    = f1_q - f2_q;
          c_off   = $signed({1'b0, idx_q});
          do_exit = 1'b1;
        end else if (rd_val > target_q) begin
          c_fm    = f2_q;
          c_f1    = f1_q - f2_q;
          c_f2    = f2_q - (f1_q - f2_q);
          do_exit = 1'b1;
        end else begin
          res_found_d = 1'b1;
          res_pos_d   = PosW'(idx_q);
          state_d     = ST_DONE;
        end
        f2_d  = c_f2;
        f1_d  = c_f1;
        fm_d  = c_fm;
        off_d = c_off;
      end
      ST_LAST: begin
        if (rd_val == target_q) begin
          probes_d    = probes_q + CntW'(1);
          res_found_d = 1'b1;
          res_pos_d   = PosW'(idx_q);
        end else begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = res_pos_q;
          out_cnt_d   = probes_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Leave the current window: probe again, check the neighbor, or give up.
    if (do_exit) begin
      priority if (c_fm > FibW'(1)) begin
        ram_re    = 1'b1;
        ram_raddr = AW'(probe_idx);
        idx_d     = probe_idx;
        state_d   = ST_PROBE;
      end else if ((c_f1 != '0) && (last_idx < {1'b0, n})) begin
        ram_re    = 1'b1;
        ram_raddr = AW'(last_idx);
        idx_d     = LenW'(last_idx);
        state_d   = ST_LAST;
      end else begin
        res_found_d = 1'b0;
        res_pos_d   = '0;
        state_d     = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    f2_q        <= f2_d;
    f1_q        <= f1_d;
    fm_q        <= fm_d;
    off_q       <= off_d;
    idx_q       <= idx_d;
    probes_q    <= probes_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.probe_count = out_cnt_q;

  // The table is never written while a search reads it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("table write overlaps a search read");

  // Every probed or checked entry lies inside the searched length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE || state_q == ST_LAST) |-> (idx_q < n))
    else $error("probe index outside the table length");

  // A new result word only appears after the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the finishing state");

  // A hit always comes from at least one comparison.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_found_q) |-> (probes_q != '0))
    else $error("hit reported with no probes");

endmodule

/* bench/tb_fibonacci_search_sorted_table.sv */
// ----------------------------------------------------------------------------
// Testbench for the Fibonacci search sorted table
// Drives write and search words through the request channel with random
// gaps and stalls, predicts every search result from a shadow copy of the
// table and the length register, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_fibonacci_search_sorted_table;
  import fss_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_WORDS  = 50;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint      VAL_MIN      = -64'sd2147483648;
  localparam longint      VAL_MAX      = 64'sd2147483647;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    req_type_e            kind;
    logic [IdxW-1:0]      index;
    logic [VALUE_W-1:0]   value;
  } table_word_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic [CntW-1:0] probe_count;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LenW-1:0]   cfg_wdata_i;

  fss_req_if #(.VALUE_WIDTH(VALUE_W)) req_if ();
  fss_rsp_if                          rsp_if ();

  fibonacci_search_sorted_table #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow of the block as seen at accepted words, and the stimulus plan.
  logic signed [VALUE_W-1:0] shadow_table [DEPTH];
  logic signed [VALUE_W-1:0] plan_table [DEPTH];
  int unsigned               table_len;
  table_word_t               pending_words [$];
  lookup_result_t            awaited_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_pushed;
  int unsigned words_taken;
  int unsigned search_cnt;
  int unsigned write_cnt;
  int unsigned hit_cnt;
  int unsigned length_cnt;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  table_word_t    drive_word;
  lookup_result_t seen;
  lookup_result_t wanted;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fibonacci search over the shadow table with the current length.
  function automatic lookup_result_t predict_lookup(input logic signed [VALUE_W-1:0] target);
    lookup_result_t res;
    int n, f2, f1, fm, offset, i, probes;
    res    = '0;
    n      = (table_len > DEPTH) ? DEPTH : table_len;
    f2     = 0;
    f1     = 1;
    fm     = 1;
    offset = -1;
    probes = 0;
    while (fm < n) begin
      f2 = f1;
      f1 = fm;
      fm = f2 + f1;
    end
    while (fm > 1) begin
      i = offset + f2;
      if (i > n - 1) i = n - 1;
      if (i < 0) i = 0;
      probes++;
      if (shadow_table[i] < target) begin
        fm     = f1;
        f1     = f2;
        f2     = fm - f1;
        offset = i;
      end else if (shadow_table[i] > target) begin
        fm = f2;
        f1 = f1 - f2;
        f2 = fm - f1;
      end else begin
        res.found       = 1'b1;
        res.position    = i[PosW-1:0];
        res.probe_count = probes[CntW-1:0];
        return res;
      end
    end
    // The last neighbor check counts as a probe only when it matches.
    if (f1 != 0 && offset + 1 < n && shadow_table[offset + 1] == target) begin
      probes++;
      res.found    = 1'b1;
      res.position = 10'(offset + 1);
    end
    res.probe_count = probes[CntW-1:0];
    return res;
  endfunction

  // Request driver: the valid stays up until the word is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_WRITE;
      req_if.entry_index <= '0;
      req_if.item_value  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        words_taken++;
        if (req_if.req_type == REQ_WRITE) begin
          shadow_table[req_if.entry_index] = $signed(req_if.item_value);
          write_cnt++;
        end else begin
          awaited_results.push_back(predict_lookup($signed(req_if.item_value)));
          search_cnt++;
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_word = pending_words.pop_front();
          req_if.valid       <= 1'b1;
          req_if.req_type    <= drive_word.kind;
          req_if.entry_index <= drive_word.index;
          req_if.item_value  <= drive_word.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_error(input string what);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) begin
      $display("%s: exp found=%0b pos=%0d probes=%0d, got found=%0b pos=%0d probes=%0d",
               what, wanted.found, wanted.position, wanted.probe_count,
               seen.found, seen.position, seen.probe_count);
    end
  endtask

  // Result monitor with random back pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen.found       = rsp_if.found;
        seen.position    = rsp_if.position;
        seen.probe_count = rsp_if.probe_count;
        if (seen.found === 1'b1) hit_cnt++;
        if (awaited_results.size() == 0) begin
          wanted = 'x;
          report_error("result word with nothing awaited");
        end else begin
          wanted = awaited_results.pop_front();
          if (seen.found !== wanted.found || seen.position !== wanted.position ||
              seen.probe_count !== wanted.probe_count) begin
            report_error("search result mismatch");
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_fibonacci_search_sorted_table: errors");
      $finish;
    end
  end

  task automatic wait_quiet();
    @(negedge clk_i);
    while (words_taken != words_pushed || awaited_results.size() != 0) @(negedge clk_i);
    // A write word gives no result, so give the block time to settle.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 45;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 45;
      end
      default: begin
        send_idle_pct  = 19;
        recv_stall_pct = 19;
      end
    endcase
  endtask

  task automatic set_table_length(input int unsigned len);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len[LenW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_len = len;
    length_cnt++;
    @(negedge clk_i);
  endtask

  task automatic push_write(input int unsigned idx, input logic [VALUE_W-1:0] val);
    pending_words.push_back('{kind: REQ_WRITE, index: idx[IdxW-1:0], value: val});
    plan_table[idx] = $signed(val);
    words_pushed++;
  endtask

  task automatic push_search(input logic [VALUE_W-1:0] val);
    // The index is ignored for searches, so it carries random noise.
    pending_words.push_back('{kind: REQ_SEARCH, index: IdxW'($urandom), value: val});
    words_pushed++;
  endtask

  // Mostly stored values, then near misses, then anything at all.
  function automatic logic [VALUE_W-1:0] pick_target();
    int unsigned n, r, k;
    n = (table_len > DEPTH) ? DEPTH : table_len;
    r = $urandom_range(99);
    k = (n > 0) ? $urandom_range(n - 1) : 0;
    if (n > 0 && r < 55) return plan_table[k];
    if (n > 0 && r < 75) return $urandom_range(1) ? plan_table[k] + 1 : plan_table[k] - 1;
    return $urandom;
  endfunction

  // Fills the whole table in non-decreasing order, from at or near the minimum to the maximum.
  task automatic fill_sorted();
    longint v;
    v = $urandom_range(1) ? VAL_MIN : VAL_MIN + $urandom_range(1000);
    for (int k = 0; k < DEPTH; k++) begin
      if (k == DEPTH - 1) v = VAL_MAX;
      push_write(k, VALUE_W'(v));
      if ($urandom_range(19) != 0) v = v + $urandom_range(8_000_000, 1);
      if (v > VAL_MAX) v = VAL_MAX;
    end
  endtask

  // Rewrites one entry, half the time keeping the order, half with any value.
  task automatic push_rewrite();
    int unsigned k;
    longint lo, hi, step;
    k = $urandom_range(DEPTH - 1);
    if ($urandom_range(1)) begin
      push_write(k, $urandom);
    end else begin
      lo = (k == 0) ? VAL_MIN : longint'(plan_table[k - 1]);
      hi = (k == DEPTH - 1) ? VAL_MAX : longint'(plan_table[k + 1]);
      if (hi < lo) begin
        push_write(k, VALUE_W'(lo));
      end else begin
        step = $urandom_range(32'(hi - lo));
        push_write(k, VALUE_W'(lo + step));
      end
    end
  endtask

  task automatic run_phase(input int unsigned len, input idle_mode_e mode, input bit pause_mid);
    set_table_length(len);
    set_idling(mode);
    for (int j = 0; j < PHASE_WORDS; j++) begin
      if (pause_mid && j == PHASE_WORDS / 2) wait_quiet();
      if ($urandom_range(9) == 0) push_rewrite();
      else push_search(pick_target());
    end
  endtask

  initial begin
    int unsigned lens [14];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    table_len          = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    words_pushed       = 0;
    words_taken        = 0;
    search_cnt         = 0;
    write_cnt          = 0;
    hit_cnt            = 0;
    length_cnt         = 0;
    error_cnt          = 0;
    cycle_cnt          = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table at the reset length, then a small table of extremes.
    set_idling(IDLE_NONE);
    push_search(32'd0);
    push_write(0, 32'h8000_0000);
    push_write(1, -32'sd100000);
    push_write(2, -32'sd1);
    push_write(3, 32'd0);
    push_write(4, 32'd1);
    push_write(5, 32'd77);
    push_write(6, 32'd100000);
    push_write(7, 32'h7fff_ffff);
    set_table_length(8);
    push_search(32'h8000_0000);
    push_search(32'h7fff_ffff);
    push_search(32'd0);
    push_search(32'd77);
    push_search(-32'sd1);
    push_search(32'd5);
    push_search(32'h7fff_fffe);
    push_search(-32'sd100001);
    // A single entry is only reached by the neighbor check.
    set_table_length(1);
    push_search(32'h8000_0000);
    push_search(32'd0);
    set_table_length(3);
    push_search(-32'sd1);
    push_search(32'd1);

    wait_quiet();
    set_idling(IDLE_SEND);
    fill_sorted();

    lens = '{1024, 2047, 1025, 0, 1, 2, 1023, $urandom_range(40, 3),
             $urandom_range(1023, 41), 1536, 5, $urandom_range(40, 3), 700, 1024};
    for (int p = 0; p < 14; p++) begin
      run_phase(lens[p], idle_mode_e'(p % 4), p == 2 || p == 9);
    end

    wait_quiet();
    $display("Covered %0d searches (%0d hits) and %0d table writes over %0d length settings,",
             search_cnt, hit_cnt, write_cnt, length_cnt);
    $display("from an empty table to saturated lengths, with random gaps and back pressure.");
    if (error_cnt == 0 && awaited_results.size() == 0) begin
      $display("tb_fibonacci_search_sorted_table: clean");
    end else begin
      $display("tb_fibonacci_search_sorted_table: errors");
    end
    $finish;
  end

endmodule
